>>> sv/hmc_pkg.sv
`timescale 1ns / 1ps

package hmc_pkg;

  localparam int unsigned PointsW      = 9;
  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned ElemW        = 24;
  localparam int unsigned FaceW        = 3;
  localparam int unsigned BcodeW       = 3;
  localparam int unsigned NumFaces     = 6;
  localparam int unsigned NumCorners   = 8;
  localparam int unsigned PaddrW       = 4;
  localparam int unsigned PdataW       = 32;

  localparam logic [PointsW-1:0] PointsRstVal = PointsW'(2);

  // Register index, taken from paddr[3:2]
  localparam logic [1:0] REG_POINTS_X = 2'd0;
  localparam logic [1:0] REG_POINTS_Y = 2'd1;
  localparam logic [1:0] REG_POINTS_Z = 2'd2;

  typedef enum logic [FaceW-1:0] {
    FACE_SOUTH  = 3'd0,
    FACE_EAST   = 3'd1,
    FACE_NORTH  = 3'd2,
    FACE_WEST   = 3'd3,
    FACE_BOTTOM = 3'd4,
    FACE_TOP    = 3'd5
  } face_e;

  // One element as handed from the front end to the face sequencer
  typedef struct packed {
    logic [ElemW-1:0]                     elem;
    logic [NumCorners-1:0][ElemW-1:0]     corner;
    logic [NumFaces-1:0][ElemW-1:0]       nbr;
    logic [NumFaces-1:0]                  bdry;
    logic                                 done;
  } elem_rec_t;

endpackage

>>> sv/hmc_front.sv
`timescale 1ns / 1ps

module hmc_front #(
  parameter int unsigned MaxPoints  = hmc_pkg::MaxPointsDef,
  parameter int unsigned QueueDepth = hmc_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         restart_i,
  input  logic [hmc_pkg::PointsW-1:0]  points_x_i,
  input  logic [hmc_pkg::PointsW-1:0]  points_y_i,
  input  logic [hmc_pkg::PointsW-1:0]  points_z_i,
  input  logic                         pop_i,
  output logic                         push_o,
  output hmc_pkg::elem_rec_t           rec_o
);

  localparam int unsigned CurW   = (MaxPoints > 2) ? $clog2(MaxPoints) : 1;
  localparam int unsigned PtW    = $clog2(MaxPoints + 1);
  localparam int unsigned CmpW   = PtW + 1;
  localparam int unsigned ProdW  = 2 * PtW;
  localparam int unsigned ElemW  = hmc_pkg::ElemW;
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);

  function automatic logic [PtW-1:0] eff_pts(input logic [hmc_pkg::PointsW-1:0] p);
    logic [PtW-1:0] r;
    if (p < hmc_pkg::PointsW'(2)) begin
      r = PtW'(2);
    end else if (32'(p) > 32'(MaxPoints)) begin
      r = PtW'(MaxPoints);
    end else begin
      r = PtW'(p);
    end
    return r;
  endfunction

  logic [PtW-1:0] px, py, pz, ex, ey, ez;
  logic [CmpW-1:0] nx, ny, nz;
  logic [CurW-1:0] cx_d, cy_d, cz_d;
  logic [hmc_pkg::NumFaces-1:0] flags_d;
  logic accept;

  logic [CurW-1:0] cx_q, cy_q, cz_q;
  logic            started_q;
  logic [CntW-1:0] inflight_q, inflight_d;

  // Stage 1: cursors and boundary flags
  logic                          s1_valid_q;
  logic [CurW-1:0]               s1_x_q, s1_y_q, s1_z_q;
  logic [PtW-1:0]                s1_px_q, s1_py_q, s1_ex_q, s1_ey_q;
  logic [hmc_pkg::NumFaces-1:0]  s1_flags_q;
  logic                          s1_done_q;

  // Stage 2: in-plane products
  logic                          s2_valid_q;
  logic [ElemW-1:0]              s2_exy_q, s2_pxy_q, s2_xe_q, s2_xc_q;
  logic [CurW-1:0]               s2_z_q;
  logic [PtW-1:0]                s2_ex_q, s2_px_q;
  logic [hmc_pkg::NumFaces-1:0]  s2_flags_q;
  logic                          s2_done_q;

  // Stage 3: element index and base corner
  logic                          s3_valid_q;
  logic [ElemW-1:0]              s3_e_q, s3_c0_q, s3_exy_q, s3_pxy_q;
  logic [PtW-1:0]                s3_ex_q, s3_px_q;
  logic [hmc_pkg::NumFaces-1:0]  s3_flags_q;
  logic                          s3_done_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (inflight_q < CntW'(QueueDepth));

  always_comb begin
    px = eff_pts(points_x_i);
    py = eff_pts(points_y_i);
    pz = eff_pts(points_z_i);
    ex = px - PtW'(1);
    ey = py - PtW'(1);
    ez = pz - PtW'(1);

    nx = CmpW'(cx_q) + CmpW'(1);
    ny = CmpW'(cy_q);
    nz = CmpW'(cz_q);
    if (nx >= CmpW'(ex)) begin
      nx = '0;
      ny = ny + CmpW'(1);
    end
    if (ny >= CmpW'(ey)) begin
      ny = '0;
      nz = nz + CmpW'(1);
    end
    if (nz >= CmpW'(ez)) begin
      nz = '0;
    end
    if (restart_i || !started_q) begin
      nx = '0;
      ny = '0;
      nz = '0;
    end
    cx_d = CurW'(nx);
    cy_d = CurW'(ny);
    cz_d = CurW'(nz);

    flags_d[hmc_pkg::FACE_SOUTH]  = (ny == '0);
    flags_d[hmc_pkg::FACE_EAST]   = (nx == CmpW'(ex) - CmpW'(1));
    flags_d[hmc_pkg::FACE_NORTH]  = (ny == CmpW'(ey) - CmpW'(1));
    flags_d[hmc_pkg::FACE_WEST]   = (nx == '0);
    flags_d[hmc_pkg::FACE_BOTTOM] = (nz == '0);
    flags_d[hmc_pkg::FACE_TOP]    = (nz == CmpW'(ez) - CmpW'(1));
  end

  always_comb begin
    inflight_d = inflight_q;
    if (accept && !pop_i) begin
      inflight_d = inflight_q + CntW'(1);
    end else if (!accept && pop_i) begin
      inflight_d = inflight_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q       <= '0;
      cy_q       <= '0;
      cz_q       <= '0;
      started_q  <= 1'b0;
      inflight_q <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      inflight_q <= inflight_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (accept) begin
        cx_q      <= cx_d;
        cy_q      <= cy_d;
        cz_q      <= cz_d;
        started_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= cx_d;
      s1_y_q     <= cy_d;
      s1_z_q     <= cz_d;
      s1_px_q    <= px;
      s1_py_q    <= py;
      s1_ex_q    <= ex;
      s1_ey_q    <= ey;
      s1_flags_q <= flags_d;
      s1_done_q  <= flags_d[hmc_pkg::FACE_EAST] && flags_d[hmc_pkg::FACE_NORTH]
                    && flags_d[hmc_pkg::FACE_TOP];
    end
    s2_exy_q   <= ElemW'(ProdW'(s1_ex_q) * ProdW'(s1_ey_q));
    s2_pxy_q   <= ElemW'(ProdW'(s1_px_q) * ProdW'(s1_py_q));
    s2_xe_q    <= ElemW'(ProdW'(s1_ex_q) * ProdW'(s1_y_q)) + ElemW'(s1_x_q);
    s2_xc_q    <= ElemW'(ProdW'(s1_px_q) * ProdW'(s1_y_q)) + ElemW'(s1_x_q);
    s2_z_q     <= s1_z_q;
    s2_ex_q    <= s1_ex_q;
    s2_px_q    <= s1_px_q;
    s2_flags_q <= s1_flags_q;
    s2_done_q  <= s1_done_q;

    s3_e_q     <= s2_xe_q + ElemW'(s2_exy_q * ElemW'(s2_z_q));
    s3_c0_q    <= s2_xc_q + ElemW'(s2_pxy_q * ElemW'(s2_z_q));
    s3_exy_q   <= s2_exy_q;
    s3_pxy_q   <= s2_pxy_q;
    s3_ex_q    <= s2_ex_q;
    s3_px_q    <= s2_px_q;
    s3_flags_q <= s2_flags_q;
    s3_done_q  <= s2_done_q;
  end

  // Corners and neighbors, written straight into the queue
  always_comb begin
    logic [ElemW-1:0] c3, c4, c7;
    c3 = s3_c0_q + ElemW'(s3_px_q);
    c4 = s3_c0_q + s3_pxy_q;
    c7 = c4 + ElemW'(s3_px_q);
    rec_o.elem      = s3_e_q;
    rec_o.corner[0] = s3_c0_q;
    rec_o.corner[1] = s3_c0_q + ElemW'(1);
    rec_o.corner[2] = c3 + ElemW'(1);
    rec_o.corner[3] = c3;
    rec_o.corner[4] = c4;
    rec_o.corner[5] = c4 + ElemW'(1);
    rec_o.corner[6] = c7 + ElemW'(1);
    rec_o.corner[7] = c7;
    rec_o.nbr[hmc_pkg::FACE_SOUTH]  = s3_e_q - ElemW'(s3_ex_q);
    rec_o.nbr[hmc_pkg::FACE_EAST]   = s3_e_q + ElemW'(1);
    rec_o.nbr[hmc_pkg::FACE_NORTH]  = s3_e_q + ElemW'(s3_ex_q);
    rec_o.nbr[hmc_pkg::FACE_WEST]   = s3_e_q - ElemW'(1);
    rec_o.nbr[hmc_pkg::FACE_BOTTOM] = s3_e_q - s3_exy_q;
    rec_o.nbr[hmc_pkg::FACE_TOP]    = s3_e_q + s3_exy_q;
    rec_o.bdry = s3_flags_q;
    rec_o.done = s3_done_q;
  end

  assign push_o = s3_valid_q;

`ifndef SYNTHESIS
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(QueueDepth))
    else $error("front: more elements in flight than queue slots");

  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart_i |=> cx_q == '0 && cy_q == '0 && cz_q == '0)
    else $error("front: restart did not return cursors to origin");

  a_idle_before_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> inflight_q == '0 && !s3_valid_q)
    else $error("front: work in flight before first transaction");
`endif

endmodule

>>> sv/hmc_queue.sv
`timescale 1ns / 1ps

module hmc_queue #(
  parameter int unsigned QueueDepth = hmc_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hmc_pkg::elem_rec_t rec_i,
  input  logic               pop_i,
  output logic               valid_o,
  output hmc_pkg::elem_rec_t rec_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  hmc_pkg::elem_rec_t slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= rec_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign rec_o   = slot_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < CntW'(QueueDepth))
    else $error("queue: push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue: pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue: occupancy above depth");
`endif

endmodule

>>> sv/hmc_back.sv
`timescale 1ns / 1ps

module hmc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  hmc_pkg::elem_rec_t          rec_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hmc_pkg::ElemW-1:0]   element_index_o,
  output logic [hmc_pkg::FaceW-1:0]   face_number_o,
  output logic [hmc_pkg::ElemW-1:0]   node_a_o,
  output logic [hmc_pkg::ElemW-1:0]   node_b_o,
  output logic [hmc_pkg::ElemW-1:0]   node_c_o,
  output logic [hmc_pkg::ElemW-1:0]   node_d_o,
  output logic [hmc_pkg::ElemW-1:0]   neighbor_index_o,
  output logic [hmc_pkg::BcodeW-1:0]  boundary_code_o,
  output logic                        last_face_o,
  output logic                        mesh_done_o
);

  localparam int unsigned ElemW = hmc_pkg::ElemW;

  hmc_pkg::face_e face_q, face_d;
  logic load;
  logic bdry;
  logic [ElemW-1:0] na, nb, nc, nd;

  logic                         out_valid_q;
  logic [ElemW-1:0]             element_index_q, node_a_q, node_b_q, node_c_q, node_d_q;
  logic [ElemW-1:0]             neighbor_index_q;
  logic [hmc_pkg::FaceW-1:0]    face_number_q;
  logic [hmc_pkg::BcodeW-1:0]   boundary_code_q;
  logic                         last_face_q, mesh_done_q;

  assign load  = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && (face_q == hmc_pkg::FACE_TOP);
  assign bdry  = rec_i.bdry[face_q];

  always_comb begin
    unique case (face_q)
      hmc_pkg::FACE_SOUTH: begin
        na = rec_i.corner[0]; nb = rec_i.corner[1];
        nc = rec_i.corner[5]; nd = rec_i.corner[4];
        face_d = hmc_pkg::FACE_EAST;
      end
      hmc_pkg::FACE_EAST: begin
        na = rec_i.corner[1]; nb = rec_i.corner[2];
        nc = rec_i.corner[6]; nd = rec_i.corner[5];
        face_d = hmc_pkg::FACE_NORTH;
      end
      hmc_pkg::FACE_NORTH: begin
        na = rec_i.corner[2]; nb = rec_i.corner[3];
        nc = rec_i.corner[7]; nd = rec_i.corner[6];
        face_d = hmc_pkg::FACE_WEST;
      end
      hmc_pkg::FACE_WEST: begin
        na = rec_i.corner[0]; nb = rec_i.corner[4];
        nc = rec_i.corner[7]; nd = rec_i.corner[3];
        face_d = hmc_pkg::FACE_BOTTOM;
      end
      hmc_pkg::FACE_BOTTOM: begin
        na = rec_i.corner[0]; nb = rec_i.corner[3];
        nc = rec_i.corner[2]; nd = rec_i.corner[1];
        face_d = hmc_pkg::FACE_TOP;
      end
      hmc_pkg::FACE_TOP: begin
        na = rec_i.corner[4]; nb = rec_i.corner[5];
        nc = rec_i.corner[6]; nd = rec_i.corner[7];
        face_d = hmc_pkg::FACE_SOUTH;
      end
      default: begin
        na = '0; nb = '0; nc = '0; nd = '0;
        face_d = hmc_pkg::FACE_SOUTH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_q      <= hmc_pkg::FACE_SOUTH;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        face_q      <= face_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      element_index_q  <= rec_i.elem;
      face_number_q    <= face_q;
      node_a_q         <= na;
      node_b_q         <= nb;
      node_c_q         <= nc;
      node_d_q         <= nd;
      neighbor_index_q <= bdry ? '0 : rec_i.nbr[face_q];
      boundary_code_q  <= bdry ? (hmc_pkg::BcodeW'(face_q) + hmc_pkg::BcodeW'(1)) : '0;
      last_face_q      <= (face_q == hmc_pkg::FACE_TOP);
      mesh_done_q      <= rec_i.done;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign element_index_o  = element_index_q;
  assign face_number_o    = face_number_q;
  assign node_a_o         = node_a_q;
  assign node_b_o         = node_b_q;
  assign node_c_o         = node_c_q;
  assign node_d_o         = node_d_q;
  assign neighbor_index_o = neighbor_index_q;
  assign boundary_code_o  = boundary_code_q;
  assign last_face_o      = last_face_q;
  assign mesh_done_o      = mesh_done_q;

`ifndef SYNTHESIS
  a_pop_on_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> load && face_q == hmc_pkg::FACE_TOP)
    else $error("back: element released before its top face");

  a_face_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(face_q))
    else $error("back: face sequencer moved without a load");

  a_last_is_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> last_face_o == (face_number_o == hmc_pkg::FACE_TOP))
    else $error("back: last-face flag out of step with face number");
`endif

endmodule

>>> sv/hex_mesh_connectivity_gen.sv
`timescale 1ns / 1ps

// Structured hex8 mesh connectivity generator. Each input transaction moves
// to the next element (x fastest, then y, then z; wraps after the last) or,
// with restart set, to element 0, and yields six face transactions in order
// south, east, north, west, bottom, top. The face sequencer emits one face
// per cycle while the result channel is ready; inputs are taken back to
// back as long as fewer than QueueDepth elements are in flight between the
// three-stage index front end and the face sequencer. The first face of an
// element passes through the three front-end stages, the queue and the
// output register. Point counts are written through the APB port at 0x0
// (x), 0x4 (y) and 0x8 (z); counts below 2 act as 2 and counts above
// MaxPoints act as MaxPoints. Write them only while the block is idle.
module hex_mesh_connectivity_gen #(
  parameter int unsigned MaxPoints  = hmc_pkg::MaxPointsDef,
  parameter int unsigned QueueDepth = hmc_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hmc_pkg::PaddrW-1:0]  paddr,
  input  logic [hmc_pkg::PdataW-1:0]  pwdata,
  output logic [hmc_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hmc_pkg::ElemW-1:0]   element_index_o,
  output logic [hmc_pkg::FaceW-1:0]   face_number_o,
  output logic [hmc_pkg::ElemW-1:0]   node_a_o,
  output logic [hmc_pkg::ElemW-1:0]   node_b_o,
  output logic [hmc_pkg::ElemW-1:0]   node_c_o,
  output logic [hmc_pkg::ElemW-1:0]   node_d_o,
  output logic [hmc_pkg::ElemW-1:0]   neighbor_index_o,
  output logic [hmc_pkg::BcodeW-1:0]  boundary_code_o,
  output logic                        last_face_o,
  output logic                        mesh_done_o
);

  logic [hmc_pkg::PointsW-1:0] points_x_q, points_y_q, points_z_q;
  logic [1:0] reg_idx;
  logic cfg_write;

  logic push, pop, q_valid;
  hmc_pkg::elem_rec_t front_rec, head_rec;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_x_q <= hmc_pkg::PointsRstVal;
      points_y_q <= hmc_pkg::PointsRstVal;
      points_z_q <= hmc_pkg::PointsRstVal;
    end else if (cfg_write) begin
      unique case (reg_idx)
        hmc_pkg::REG_POINTS_X: points_x_q <= pwdata[hmc_pkg::PointsW-1:0];
        hmc_pkg::REG_POINTS_Y: points_y_q <= pwdata[hmc_pkg::PointsW-1:0];
        hmc_pkg::REG_POINTS_Z: points_z_q <= pwdata[hmc_pkg::PointsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hmc_pkg::REG_POINTS_X: prdata = hmc_pkg::PdataW'(points_x_q);
      hmc_pkg::REG_POINTS_Y: prdata = hmc_pkg::PdataW'(points_y_q);
      hmc_pkg::REG_POINTS_Z: prdata = hmc_pkg::PdataW'(points_z_q);
      default:               prdata = '0;
    endcase
  end

  hmc_front #(
    .MaxPoints  (MaxPoints),
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .points_x_i (points_x_q),
    .points_y_i (points_y_q),
    .points_z_i (points_z_q),
    .pop_i      (pop),
    .push_o     (push),
    .rec_o      (front_rec)
  );

  hmc_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (head_rec)
  );

  hmc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (q_valid),
    .rec_i            (head_rec),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .element_index_o  (element_index_o),
    .face_number_o    (face_number_o),
    .node_a_o         (node_a_o),
    .node_b_o         (node_b_o),
    .node_c_o         (node_c_o),
    .node_d_o         (node_d_o),
    .neighbor_index_o (neighbor_index_o),
    .boundary_code_o  (boundary_code_o),
    .last_face_o      (last_face_o),
    .mesh_done_o      (mesh_done_o)
  );

endmodule

>>> tb/sv/hmc_face_checker.sv
`timescale 1ns / 1ps

module hmc_face_checker
  import hmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [PdataW-1:0]   pwdata,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  logic                restart_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [ElemW-1:0]    element_index_o,
  input  logic [FaceW-1:0]    face_number_o,
  input  logic [ElemW-1:0]    node_a_o,
  input  logic [ElemW-1:0]    node_b_o,
  input  logic [ElemW-1:0]    node_c_o,
  input  logic [ElemW-1:0]    node_d_o,
  input  logic [ElemW-1:0]    neighbor_index_o,
  input  logic [BcodeW-1:0]   boundary_code_o,
  input  logic                last_face_o,
  input  logic                mesh_done_o,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  localparam logic [BcodeW-1:0] BcodeNone = '0;

  typedef struct packed {
    logic [ElemW-1:0]  elem;
    face_e             face;
    logic [ElemW-1:0]  node_a;
    logic [ElemW-1:0]  node_b;
    logic [ElemW-1:0]  node_c;
    logic [ElemW-1:0]  node_d;
    logic [ElemW-1:0]  nbr;
    logic [BcodeW-1:0] bcode;
    logic              last;
    logic              done;
  } face_rec_t;

  face_rec_t          face_q[$];
  logic [PointsW-1:0] grid_x, grid_y, grid_z;
  int unsigned        at_x, at_y, at_z;
  logic               begun;
  int unsigned        errors;

  assign errors_o = errors;

  function automatic longint unsigned clamp_points(input logic [PointsW-1:0] p);
    if (p < 2) return 2;
    if (p > MaxPointsDef) return MaxPointsDef;
    return longint'(p);
  endfunction

  // Step the cursor (next element, or element 0) and queue its six faces
  task automatic enumerate_faces(input logic restart);
    longint unsigned px, py, pz, ex, ey, ez, exy, pxy, elem, c0, nbr;
    longint unsigned corner [NumCorners];
    int unsigned     nx, ny, nz;
    int              sel [4];
    logic            bdry, last_elem;
    face_rec_t       rec;
    px = clamp_points(grid_x);
    py = clamp_points(grid_y);
    pz = clamp_points(grid_z);
    ex = px - 1;
    ey = py - 1;
    ez = pz - 1;
    if (restart || !begun) begin
      at_x = 0;
      at_y = 0;
      at_z = 0;
    end else begin
      // cursors beyond a shrunken grid wrap and carry on advance
      nx = at_x + 1;
      ny = at_y;
      nz = at_z;
      if (nx >= ex) begin
        nx = 0;
        ny = ny + 1;
      end
      if (ny >= ey) begin
        ny = 0;
        nz = nz + 1;
      end
      if (nz >= ez) nz = 0;
      at_x = nx;
      at_y = ny;
      at_z = nz;
    end
    begun = 1'b1;
    exy = ex * ey;
    pxy = px * py;
    elem = at_x + ex * at_y + exy * at_z;
    c0 = pxy * at_z + px * at_y + at_x;
    corner[0] = c0;
    corner[1] = c0 + 1;
    corner[2] = c0 + px + 1;
    corner[3] = c0 + px;
    for (int i = 4; i < NumCorners; i++) corner[i] = corner[i-4] + pxy;
    last_elem = (at_x == ex - 1) && (at_y == ey - 1) && (at_z == ez - 1);
    for (int f = 0; f < NumFaces; f++) begin
      rec.face = face_e'(f);
      case (rec.face)
        FACE_SOUTH: begin
          sel = '{0, 1, 5, 4};
          bdry = (at_y == 0);
          nbr = elem - ex;
        end
        FACE_EAST: begin
          sel = '{1, 2, 6, 5};
          bdry = (at_x == ex - 1);
          nbr = elem + 1;
        end
        FACE_NORTH: begin
          sel = '{2, 3, 7, 6};
          bdry = (at_y == ey - 1);
          nbr = elem + ex;
        end
        FACE_WEST: begin
          sel = '{0, 4, 7, 3};
          bdry = (at_x == 0);
          nbr = elem - 1;
        end
        FACE_BOTTOM: begin
          sel = '{0, 3, 2, 1};
          bdry = (at_z == 0);
          nbr = elem - exy;
        end
        default: begin
          sel = '{4, 5, 6, 7};
          bdry = (at_z == ez - 1);
          nbr = elem + exy;
        end
      endcase
      rec.elem   = elem[ElemW-1:0];
      rec.node_a = corner[sel[0]][ElemW-1:0];
      rec.node_b = corner[sel[1]][ElemW-1:0];
      rec.node_c = corner[sel[2]][ElemW-1:0];
      rec.node_d = corner[sel[3]][ElemW-1:0];
      rec.nbr    = bdry ? '0 : nbr[ElemW-1:0];
      rec.bcode  = bdry ? BcodeW'(f + 1) : BcodeNone;
      rec.last   = (rec.face == FACE_TOP);
      rec.done   = last_elem;
      face_q.push_back(rec);
    end
  endtask

  task automatic check_field(input string name, input logic [ElemW-1:0] want,
                             input logic [ElemW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic compare_face();
    face_rec_t want;
    if (face_q.size() == 0) begin
      $error("face transaction with nothing expected: element %0d face %0d",
             element_index_o, face_number_o);
      errors++;
    end else begin
      want = face_q.pop_front();
      check_field("element_index", want.elem, element_index_o);
      check_field("face_number", ElemW'(want.face), ElemW'(face_number_o));
      check_field("node_a", want.node_a, node_a_o);
      check_field("node_b", want.node_b, node_b_o);
      check_field("node_c", want.node_c, node_c_o);
      check_field("node_d", want.node_d, node_d_o);
      check_field("neighbor_index", want.nbr, neighbor_index_o);
      check_field("boundary_code", ElemW'(want.bcode), ElemW'(boundary_code_o));
      check_field("last_face", ElemW'(want.last), ElemW'(last_face_o));
      check_field("mesh_done", ElemW'(want.done), ElemW'(mesh_done_o));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x = PointsRstVal;
      grid_y = PointsRstVal;
      grid_z = PointsRstVal;
      at_x = 0;
      at_y = 0;
      at_z = 0;
      begun = 1'b0;
      errors = 0;
      face_q.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_POINTS_X: grid_x = pwdata[PointsW-1:0];
          REG_POINTS_Y: grid_y = pwdata[PointsW-1:0];
          REG_POINTS_Z: grid_z = pwdata[PointsW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) enumerate_faces(restart_i);
      if (out_valid_o && out_ready_i) compare_face();
      pending_o <= face_q.size();
    end
  end

endmodule

>>> tb/sv/tb_hex_mesh_connectivity_gen.sv
`timescale 1ns / 1ps

module tb_hex_mesh_connectivity_gen;
  import hmc_pkg::*;

  localparam int unsigned TotalElements = 150;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 3000;
  localparam logic [1:0]  RegUnmapped   = 2'd3;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PaddrW-1:0]   paddr       = '0;
  logic [PdataW-1:0]   pwdata      = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ElemW-1:0]    element_index_o;
  logic [FaceW-1:0]    face_number_o;
  logic [ElemW-1:0]    node_a_o, node_b_o, node_c_o, node_d_o;
  logic [ElemW-1:0]    neighbor_index_o;
  logic [BcodeW-1:0]   boundary_code_o;
  logic                last_face_o;
  logic                mesh_done_o;

  int unsigned errors, pending;
  int unsigned elements_sent = 0;
  int unsigned faces_seen = 0;
  int unsigned meshes = 0;
  int unsigned idle_cycles = 0;
  bit          tx_no_idle = 1'b0;
  bit          rx_no_idle = 1'b0;
  bit          hold_req = 1'b0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  hex_mesh_connectivity_gen i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .restart_i, .out_valid_o, .out_ready_i,
    .element_index_o, .face_number_o, .node_a_o, .node_b_o, .node_c_o, .node_d_o,
    .neighbor_index_o, .boundary_code_o, .last_face_o, .mesh_done_o
  );

  hmc_face_checker i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i, .in_ready_o, .restart_i, .out_valid_o, .out_ready_i,
    .element_index_o, .face_number_o, .node_a_o, .node_b_o, .node_c_o, .node_d_o,
    .neighbor_index_o, .boundary_code_o, .last_face_o, .mesh_done_o,
    .errors_o(errors), .pending_o(pending)
  );

  task automatic write_reg(input logic [1:0] idx, input logic [PointsW-1:0] val);
    logic [PdataW-1:0] word;
    // junk in the upper bits must be dropped by the register
    word = $urandom;
    word[PointsW-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_mesh(input logic [PointsW-1:0] px, input logic [PointsW-1:0] py,
                          input logic [PointsW-1:0] pz);
    write_reg(REG_POINTS_X, px);
    write_reg(REG_POINTS_Y, py);
    write_reg(REG_POINTS_Z, pz);
    meshes++;
  endtask

  task automatic send_element(input logic restart);
    int unsigned gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    elements_sent++;
  endtask

  // Hold the sender until every face has come back, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [PointsW-1:0] pick_points();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return PointsW'($urandom_range(0, 1));
    if (r == 1) return PointsW'($urandom_range(257, 511));
    if (r == 2) return PointsW'(MaxPointsDef);
    return PointsW'($urandom_range(2, 6));
  endfunction

  // Receiver: random gaps per transaction, one long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = rx_no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid_o && out_ready_i) faces_seen <= faces_seen + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset grid is a single element: first step ignores restart, then wrap
    send_element(1'b0);
    send_element(1'b1);
    send_element(1'b0);
    drain();

    // full walk of a 2x2x2 element grid, wrap, restart
    set_mesh(PointsW'(3), PointsW'(3), PointsW'(3));
    repeat (9) send_element(1'b0);
    send_element(1'b1);
    drain();

    // counts below 2 act as 2, all bits set clamps; unmapped address ignored
    set_mesh(PointsW'(0), PointsW'(1), PointsW'(511));
    write_reg(RegUnmapped, 9'h1ff);
    repeat (4) send_element(1'b0);
    drain();

    // largest grid, cursor carried over from the previous setting
    set_mesh(PointsW'(MaxPointsDef), PointsW'(MaxPointsDef), PointsW'(MaxPointsDef));
    send_element(1'b0);
    send_element(1'b0);
    send_element(1'b1);
    drain();

    set_mesh(PointsW'(257), PointsW'(3), PointsW'(2));
    repeat (3) send_element(1'b0);
    drain();

    // back up the result side while the sender keeps pushing
    set_mesh(PointsW'(4), PointsW'(3), PointsW'(3));
    tx_no_idle = 1'b1;
    hold_req = 1'b1;
    repeat (12) send_element($urandom_range(0, 9) == 0);
    tx_no_idle = 1'b0;
    drain();

    while (elements_sent < TotalElements) begin
      set_mesh(pick_points(), pick_points(), pick_points());
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(8, 30);
      repeat (n) send_element($urandom_range(0, 9) == 0);
      drain();
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;

    $display("summary: %0d elements over %0d grid settings, %0d face transactions checked",
             elements_sent, meshes, faces_seen);
    $display("summary: clamped and out-of-range counts, wrap, restart and back-pressure");
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
